[hw/rtl/accumulator_machine_execute_defines.svh]
// Assertion helpers shared by the execute block.
`ifndef ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define AMX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/amx_pkg.sv]
package amx_pkg;

  localparam int MEM_DEPTH_DEF  = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W   = 4;
  localparam int ADDR_W = 9;
  localparam int WORD_W = 32;
  localparam int PC_W   = 16;

  localparam logic [OP_W-1:0] OP_SET   = 4'd0;
  localparam logic [OP_W-1:0] OP_LDR   = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_INC   = 4'd3;
  localparam logic [OP_W-1:0] OP_DEC   = 4'd4;
  localparam logic [OP_W-1:0] OP_STR   = 4'd5;
  localparam logic [OP_W-1:0] OP_SHW   = 4'd6;
  localparam logic [OP_W-1:0] OP_PAUSE = 4'd7;
  localparam logic [OP_W-1:0] OP_END   = 4'd8;
  localparam logic [OP_W-1:0] OP_BAD   = 4'd9;

  // ADD modes
  localparam logic [1:0] ADD_ACC = 2'd1;
  localparam logic [1:0] ADD_TWO = 2'd2;
  localparam logic [1:0] ADD_MEM = 2'd3;

  // SET value sources
  localparam logic [1:0] SRC_IMM  = 2'd0;
  localparam logic [1:0] SRC_MEM  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  // SHW targets
  localparam logic [2:0] SHOW_ACC   = 3'd0;
  localparam logic [2:0] SHOW_ICR   = 3'd1;
  localparam logic [2:0] SHOW_MAR   = 3'd2;
  localparam logic [2:0] SHOW_MDR   = 3'd3;
  localparam logic [2:0] SHOW_STATE = 3'd4;
  localparam logic [2:0] SHOW_MEM   = 3'd5;
  localparam logic [2:0] SHOW_NONE  = 3'd6;

  // Control state code reported by SHW: EXECUTE
  localparam logic [WORD_W-1:0] CTRL_EXECUTE = 32'd2;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [1:0]        add_mode;
    logic [1:0]        set_src;
    logic [2:0]        tgt;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] c;
    logic [WORD_W-1:0] imm;
    logic              a_ok;
    logic              b_ok;
    logic              c_ok;
    logic              err;
  } amx_instr_t;

endpackage

[hw/rtl/amx_req_if.sv]
interface amx_req_if;
  import amx_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic [ADDR_W-1:0]        addr_a;
  logic [ADDR_W-1:0]        addr_b;
  logic [ADDR_W-1:0]        addr_c;
  logic [1:0]               operand_count;
  logic [1:0]               source_kind;
  logic signed [WORD_W-1:0] immediate;
  logic [2:0]               show_target;

  modport source (
    output valid, req_type, addr_a, addr_b, addr_c, operand_count, source_kind,
           immediate, show_target,
    input  ready
  );

  modport sink (
    input  valid, req_type, addr_a, addr_b, addr_c, operand_count, source_kind,
           immediate, show_target,
    output ready
  );
endinterface

[hw/rtl/amx_res_if.sv]
interface amx_res_if;
  import amx_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     shown;
  logic signed [WORD_W-1:0] shown_value;
  logic                     halted;
  logic                     paused;
  logic signed [WORD_W-1:0] acc_value;
  logic [PC_W-1:0]          next_pc;
  logic                     addr_error;
  logic                     unknown_op;

  modport source (
    output valid, shown, shown_value, halted, paused, acc_value, next_pc,
           addr_error, unknown_op,
    input  ready
  );

  modport sink (
    input  valid, shown, shown_value, halted, paused, acc_value, next_pc,
           addr_error, unknown_op,
    output ready
  );
endinterface

[hw/rtl/amx_ram.sv]
module amx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end
endmodule

[hw/rtl/amx_front.sv]
module amx_front #(
  parameter int MEM_DEPTH = amx_pkg::MEM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  amx_req_if.sink             req,
  output logic                q_valid,
  input  logic                q_ready,
  output amx_pkg::amx_instr_t q_data
);
  import amx_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam logic [ADDR_W-1:0] ADDR_LIM = ADDR_W'(MEM_DEPTH);

  amx_instr_t      dec;
  amx_instr_t      slots [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;
  logic            use_a;
  logic            use_b;
  logic            use_c;

  // Classify the item: normalize modes, flag the operands it touches.
  always_comb begin
    dec          = '0;
    use_a        = 1'b0;
    use_b        = 1'b0;
    use_c        = 1'b0;
    dec.a        = req.addr_a;
    dec.b        = req.addr_b;
    dec.c        = req.addr_c;
    dec.imm      = req.immediate;
    dec.a_ok     = req.addr_a < ADDR_LIM;
    dec.b_ok     = req.addr_b < ADDR_LIM;
    dec.c_ok     = req.addr_c < ADDR_LIM;
    dec.add_mode = (req.operand_count == 2'd0) ? ADD_ACC : req.operand_count;
    dec.set_src  = (req.source_kind > SRC_ZERO) ? SRC_ZERO : req.source_kind;
    dec.tgt      = (req.show_target > SHOW_NONE) ? SHOW_NONE : req.show_target;
    case (req.req_type)
      OP_SET: begin
        dec.op = OP_SET;
        use_a  = 1'b1;
        use_b  = dec.set_src == SRC_MEM;
      end
      OP_LDR: begin
        dec.op = OP_LDR;
        use_a  = 1'b1;
      end
      OP_ADD: begin
        dec.op = OP_ADD;
        use_a  = 1'b1;
        use_b  = dec.add_mode != ADD_ACC;
        use_c  = dec.add_mode == ADD_MEM;
      end
      OP_INC: begin
        dec.op = OP_INC;
        use_a  = 1'b1;
      end
      OP_DEC: begin
        dec.op = OP_DEC;
        use_a  = 1'b1;
      end
      OP_STR: begin
        dec.op = OP_STR;
        use_a  = 1'b1;
      end
      OP_SHW: begin
        dec.op = OP_SHW;
        use_a  = dec.tgt == SHOW_MEM;
      end
      OP_PAUSE: dec.op = OP_PAUSE;
      OP_END:   dec.op = OP_END;
      default:  dec.op = OP_BAD;
    endcase
    dec.err = (use_a && !dec.a_ok) || (use_b && !dec.b_ok) || (use_c && !dec.c_ok);
  end

  assign req.ready = count != CW'(QDEPTH);
  assign push      = req.valid && req.ready;
  assign q_valid   = count != '0;
  assign pop       = q_valid && q_ready;
  assign q_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end
endmodule

[hw/rtl/amx_back.sv]
`include "accumulator_machine_execute_defines.svh"

module amx_back #(
  parameter int MEM_DEPTH  = amx_pkg::MEM_DEPTH_DEF,
  parameter int DATA_WIDTH = amx_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  amx_pkg::amx_instr_t q_data,
  amx_res_if.source           res
);
  import amx_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int D  = DATA_WIDTH;

  logic                  pop;
  logic                  x_fire;
  logic                  r_valid;
  amx_instr_t            r_ins;
  logic [AW-1:0]         qa_idx;
  logic [AW-1:0]         qb_idx;
  logic [AW-1:0]         a_idx;
  logic [AW-1:0]         c_idx;
  logic [D-1:0]          ram_a;
  logic [D-1:0]          ram_b;
  logic                  vld_a;
  logic                  vld_b;
  logic                  fwd_a;
  logic                  fwd_b;
  logic [D-1:0]          fwd_data;
  logic [MEM_DEPTH-1:0]  mem_vld;

  logic [D-1:0]          acc;
  logic [D-1:0]          acc_next;
  logic [D-1:0]          mdr;
  logic [D-1:0]          mdr_next;
  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  logic                  halt;
  logic                  halt_next;

  logic                  wr_want;
  logic                  wr_ok;
  logic                  wr_en;
  logic [AW-1:0]         wr_idx;
  logic [D-1:0]          wr_data;
  logic [D-1:0]          va;
  logic [D-1:0]          vb;
  logic [D-1:0]          imm_d;
  logic [D-1:0]          set_val;
  logic [D-1:0]          sum;
  logic                  shown;
  logic                  paused;
  logic                  unknown;
  logic [WORD_W-1:0]     sval;

  logic                  o_valid;
  logic                  o_shown;
  logic [WORD_W-1:0]     o_shown_value;
  logic                  o_halted;
  logic                  o_paused;
  logic [WORD_W-1:0]     o_acc_value;
  logic [PC_W-1:0]       o_next_pc;
  logic                  o_addr_error;
  logic                  o_unknown_op;

  assign x_fire  = r_valid && (!o_valid || res.ready);
  assign q_ready = !r_valid || x_fire;
  assign pop     = q_valid && q_ready;
  assign qa_idx  = q_data.a[AW-1:0];
  assign qb_idx  = q_data.b[AW-1:0];
  assign a_idx   = r_ins.a[AW-1:0];
  assign c_idx   = r_ins.c[AW-1:0];

  amx_ram #(
    .WIDTH (D),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_idx),
    .wdata  (wr_data),
    .re     (pop),
    .raddr0 (qa_idx),
    .raddr1 (qb_idx),
    .rdata0 (ram_a),
    .rdata1 (ram_b)
  );

  // Operand select: bad address reads zero, the write retiring on the read
  // edge wins over the RAM, an entry never written reads zero.
  always_comb begin
    if (!r_ins.a_ok) begin
      va = '0;
    end else if (fwd_a) begin
      va = fwd_data;
    end else begin
      va = vld_a ? ram_a : '0;
    end
    if (!r_ins.b_ok) begin
      vb = '0;
    end else if (fwd_b) begin
      vb = fwd_data;
    end else begin
      vb = vld_b ? ram_b : '0;
    end
  end

  always_comb begin
    imm_d = D'($signed(r_ins.imm));
    sum   = va + ((r_ins.add_mode == ADD_ACC) ? acc : vb);
    case (r_ins.set_src)
      SRC_IMM: set_val = imm_d;
      SRC_MEM: set_val = vb;
      default: set_val = '0;
    endcase
  end

  always_comb begin
    acc_next  = acc;
    mdr_next  = mdr;
    pc_next   = pc;
    halt_next = halt;
    wr_want   = 1'b0;
    wr_ok     = r_ins.a_ok;
    wr_idx    = a_idx;
    wr_data   = acc;
    shown     = 1'b0;
    sval      = '0;
    paused    = 1'b0;
    unknown   = 1'b0;
    if (!halt) begin
      pc_next = pc + 1'b1;
      case (r_ins.op)
        OP_SET: begin
          mdr_next = set_val;
          wr_want  = 1'b1;
          wr_data  = set_val;
        end
        OP_LDR: begin
          mdr_next = va;
          acc_next = va;
        end
        OP_ADD: begin
          if (r_ins.add_mode == ADD_MEM) begin
            wr_want = 1'b1;
            wr_ok   = r_ins.c_ok;
            wr_idx  = c_idx;
            wr_data = sum;
          end else begin
            acc_next = sum;
          end
        end
        OP_INC: begin
          wr_want = 1'b1;
          wr_data = va + 1'b1;
        end
        OP_DEC: begin
          wr_want = 1'b1;
          wr_data = va - 1'b1;
        end
        OP_STR: begin
          mdr_next = acc;
          wr_want  = 1'b1;
          wr_data  = acc;
        end
        OP_SHW: begin
          shown = 1'b1;
          // ICR and MAR both hold the fetched PC at this point
          case (r_ins.tgt)
            SHOW_ACC:   sval = WORD_W'($signed(acc));
            SHOW_ICR:   sval = WORD_W'(pc);
            SHOW_MAR:   sval = WORD_W'(pc);
            SHOW_MDR:   sval = WORD_W'($signed(mdr));
            SHOW_STATE: sval = CTRL_EXECUTE;
            SHOW_MEM:   sval = WORD_W'($signed(va));
            default:    shown = 1'b0;
          endcase
        end
        OP_PAUSE: paused = 1'b1;
        OP_END: begin
          halt_next = 1'b1;
          pc_next   = pc;
        end
        default: unknown = 1'b1;
      endcase
    end
    wr_en = x_fire && wr_want && wr_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      o_valid <= 1'b0;
      acc     <= '0;
      mdr     <= '0;
      pc      <= '0;
      halt    <= 1'b0;
      mem_vld <= '0;
    end else begin
      if (pop) begin
        r_valid <= 1'b1;
      end else if (x_fire) begin
        r_valid <= 1'b0;
      end
      if (x_fire) begin
        o_valid <= 1'b1;
        acc     <= acc_next;
        mdr     <= mdr_next;
        pc      <= pc_next;
        halt    <= halt_next;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
      if (wr_en) begin
        mem_vld[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_ins    <= q_data;
      vld_a    <= mem_vld[qa_idx];
      vld_b    <= mem_vld[qb_idx];
      fwd_a    <= wr_en && (wr_idx == qa_idx);
      fwd_b    <= wr_en && (wr_idx == qb_idx);
      fwd_data <= wr_data;
    end
    if (x_fire) begin
      o_shown       <= shown;
      o_shown_value <= sval;
      o_halted      <= halt_next;
      o_paused      <= paused;
      o_acc_value   <= WORD_W'($signed(acc_next));
      o_next_pc     <= pc_next;
      o_addr_error  <= !halt && r_ins.err;
      o_unknown_op  <= unknown;
    end
  end

  assign res.valid       = o_valid;
  assign res.shown       = o_shown;
  assign res.shown_value = o_shown_value;
  assign res.halted      = o_halted;
  assign res.paused      = o_paused;
  assign res.acc_value   = o_acc_value;
  assign res.next_pc     = o_next_pc;
  assign res.addr_error  = o_addr_error;
  assign res.unknown_op  = o_unknown_op;

  `AMX_ASSERT_NEXT(a_halt_sticky, clk, rst, halt, halt, "halt flag dropped without reset")
  `AMX_ASSERT_NOW(a_no_write_halted, clk, rst, wr_en, !halt, "memory write while halted")
  `AMX_ASSERT_NEXT(a_frozen, clk, rst, halt, $stable(pc) && $stable(acc), "state moved while halted")
  `AMX_ASSERT_NOW(a_no_overrun, clk, rst, o_valid && !res.ready, !x_fire, "result overwritten")
endmodule

[hw/rtl/accumulator_machine_execute.sv]
// Channel | Dir | Payload
// req     | in  | req_type, addr_a, addr_b, addr_c, operand_count, source_kind,
//         |     | immediate, show_target (one decoded instruction per item)
// res     | out | shown, shown_value, halted, paused, acc_value, next_pc,
//         |     | addr_error, unknown_op (one result per item)
//
// Sustained rate is one item per cycle while res.ready stays high; an item is
// held in a queue slot, then in the operand register, then its result is
// registered. The registered read of the data RAM sets the stage between queue
// and execute; both operands come from its two read ports at once. Reset (rst,
// synchronous) needs no clearing pass: the data words are cleared by a row of
// per-word valid bits. When res.ready is low with a result pending, the result
// register holds, execute waits, and the four-item queue takes items until full.
module accumulator_machine_execute #(
  parameter int MEM_DEPTH  = amx_pkg::MEM_DEPTH_DEF,
  parameter int DATA_WIDTH = amx_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  amx_req_if.sink   req,
  amx_res_if.source res
);
  import amx_pkg::*;

  // Classified instruction between the front queue and the back end
  logic       q_valid;
  logic       q_ready;
  amx_instr_t q_data;

  // Front: decode opcode, normalize ADD/SET/SHW modes, flag bad addresses,
  // and hold items in a short queue so a brief result stall does not reach
  // the input; a long one fills the queue and drops req.ready.
  amx_front #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  // Back: read both operands from the data RAM, then execute against the
  // accumulator, PC and MDR, write back and register the result. A write that
  // retires on the same edge as the next read is forwarded into that read.
  amx_back #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .res     (res)
  );
endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import amx_pkg::*;

  // Opcode, mode, source and target values that the package leaves unnamed.
  // The block must fold each of them into a defined behavior.
  localparam logic [OP_W-1:0] OP_TOP      = 4'd15;
  localparam logic [1:0]      ADD_DEFAULT = 2'd0;
  localparam logic [1:0]      SRC_SPARE   = 2'd3;
  localparam logic [2:0]      SHOW_SPARE  = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          REPORT_MAX  = 10;

  // One decoded instruction as it travels on the request channel.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        a;
    logic [ADDR_W-1:0]        b;
    logic [ADDR_W-1:0]        c;
    logic [1:0]               cnt;
    logic [1:0]               src;
    logic signed [WORD_W-1:0] imm;
    logic [2:0]               tgt;
  } instr_t;

  // What the machine reports after one instruction.
  typedef struct packed {
    logic              shown;
    logic [WORD_W-1:0] shown_value;
    logic              halted;
    logic              paused;
    logic [WORD_W-1:0] acc_value;
    logic [PC_W-1:0]   next_pc;
    logic              addr_error;
    logic              unknown_op;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  amx_req_if req ();
  amx_res_if res ();

  accumulator_machine_execute DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  always #5 clk = ~clk;

  // Machine state as the predictor sees it.
  logic [WORD_W-1:0] m_acc;
  logic [PC_W-1:0]   m_pc;
  logic [PC_W-1:0]   m_icr;
  logic [PC_W-1:0]   m_mar;
  logic [WORD_W-1:0] m_mdr;
  logic [WORD_W-1:0] m_mem [MEM_DEPTH_DEF];
  logic              m_halt;
  logic              bad_access;

  outcome_t    outcome_q [$];
  int unsigned cycle_cnt = 0;
  int          fault_cnt = 0;
  int          result_idx = 0;

  // Sender pacing: bursts of random length separated by random gaps.
  bit gaps_on    = 1'b1;
  int burst_left = 1;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Out-of-range reads give zero and flag the item.
  function automatic logic [WORD_W-1:0] mem_read(logic [ADDR_W-1:0] adr);
    if (adr < MEM_DEPTH_DEF) return m_mem[adr];
    bad_access = 1'b1;
    return '0;
  endfunction

  // Out-of-range writes are dropped and flag the item.
  function automatic void mem_write(logic [ADDR_W-1:0] adr, logic [WORD_W-1:0] val);
    if (adr < MEM_DEPTH_DEF) m_mem[adr] = val;
    else bad_access = 1'b1;
  endfunction

  // Execute one instruction on the shadow machine and return its report.
  function automatic outcome_t run_instr(instr_t it);
    outcome_t          o;
    logic [WORD_W-1:0] v;
    o = '0;
    bad_access = 1'b0;
    if (!m_halt) begin
      // Fetch: ICR and MAR take the PC before anything else.
      m_icr = m_pc;
      m_mar = m_pc;
      case (it.op)
        OP_SET: begin
          case (it.src)
            SRC_IMM: v = it.imm;
            SRC_MEM: v = mem_read(it.b);
            default: v = '0;
          endcase
          m_mar = PC_W'(it.a);
          m_mdr = v;
          mem_write(it.a, v);
        end
        OP_LDR: begin
          m_mar = PC_W'(it.a);
          v = mem_read(it.a);
          m_mdr = v;
          m_acc = v;
        end
        OP_ADD: begin
          if (it.cnt == ADD_TWO || it.cnt == ADD_MEM) begin
            v = mem_read(it.a);
            v = v + mem_read(it.b);
            if (it.cnt == ADD_TWO) m_acc = v;
            else mem_write(it.c, v);
          end else begin
            // A count of zero behaves as the one-operand mode.
            m_acc = m_acc + mem_read(it.a);
          end
        end
        OP_INC: begin
          v = mem_read(it.a);
          mem_write(it.a, v + 1'b1);
        end
        OP_DEC: begin
          v = mem_read(it.a);
          mem_write(it.a, v - 1'b1);
        end
        OP_STR: begin
          m_mar = PC_W'(it.a);
          m_mdr = m_acc;
          mem_write(it.a, m_acc);
        end
        OP_SHW: begin
          o.shown = 1'b1;
          case (it.tgt)
            SHOW_ACC:   o.shown_value = m_acc;
            SHOW_ICR:   o.shown_value = WORD_W'(m_icr);
            SHOW_MAR:   o.shown_value = WORD_W'(m_mar);
            SHOW_MDR:   o.shown_value = m_mdr;
            SHOW_STATE: o.shown_value = CTRL_EXECUTE;
            SHOW_MEM:   o.shown_value = mem_read(it.a);
            default:    o.shown = 1'b0;
          endcase
        end
        OP_PAUSE: o.paused = 1'b1;
        OP_END:   m_halt = 1'b1;
        default:  o.unknown_op = 1'b1;
      endcase
      // END holds the PC; everything else advances it.
      if (it.op != OP_END) m_pc = m_pc + 1'b1;
    end
    o.halted     = m_halt;
    o.acc_value  = m_acc;
    o.next_pc    = m_pc;
    o.addr_error = bad_access;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic instr_t mk(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                                logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] c,
                                logic [1:0] cnt, logic [1:0] src,
                                logic [WORD_W-1:0] imm, logic [2:0] tgt);
    instr_t it;
    it.op  = op;
    it.a   = a;
    it.b   = b;
    it.c   = c;
    it.cnt = cnt;
    it.src = src;
    it.imm = imm;
    it.tgt = tgt;
    return it;
  endfunction

  // Favor a small window so that words get written and read back often;
  // hit the top of memory and the invalid range now and then.
  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return ADDR_W'($urandom_range(0, 7));
    if (r < 75) return ADDR_W'($urandom_range(0, MEM_DEPTH_DEF - 1));
    if (r < 85) return ADDR_W'($urandom_range(MEM_DEPTH_DEF - 8, MEM_DEPTH_DEF + 7));
    return ADDR_W'($urandom_range(MEM_DEPTH_DEF, 511));
  endfunction

  // Random instruction of any kind but END, which would freeze the block.
  function automatic instr_t rand_instr();
    instr_t      it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 14)      it.op = OP_SET;
    else if (r < 26) it.op = OP_LDR;
    else if (r < 44) it.op = OP_ADD;
    else if (r < 52) it.op = OP_INC;
    else if (r < 60) it.op = OP_DEC;
    else if (r < 72) it.op = OP_STR;
    else if (r < 90) it.op = OP_SHW;
    else if (r < 95) it.op = OP_PAUSE;
    else             it.op = OP_BAD + OP_W'($urandom_range(0, OP_TOP - OP_BAD));
    it.a   = pick_addr();
    it.b   = pick_addr();
    it.c   = pick_addr();
    it.cnt = 2'($urandom_range(0, 3));
    it.src = 2'($urandom_range(0, 3));
    it.tgt = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    // Small values make carries across words and back to zero likely.
    if (r < 2)       it.imm = $signed(WORD_W'($urandom_range(0, 6))) - 3;
    else if (r == 2) it.imm = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else             it.imm = $urandom;
    return it;
  endfunction

  // After each item, either keep valid high for the next one or open a gap.
  task automatic pace();
    int gap;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Drive one instruction, hold it until accepted, then record its outcome.
  task automatic send_instr(instr_t it);
    req.valid         <= 1'b1;
    req.req_type      <= it.op;
    req.addr_a        <= it.a;
    req.addr_b        <= it.b;
    req.addr_c        <= it.c;
    req.operand_count <= it.cnt;
    req.source_kind   <= it.src;
    req.immediate     <= it.imm;
    req.show_target   <= it.tgt;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    outcome_q.insert(outcome_q.size(), run_instr(it));
    pace();
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Look at the registers, an out-of-range memory read and a spare show target straight out of reset.
  task automatic test_power_on_view();
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ICR));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_STATE));
    send_instr(mk(OP_SHW, ADDR_W'(MEM_DEPTH_DEF), 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_MEM));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_SPARE));
    drain();
  endtask

  // Every opcode but END, every ADD and SET mode and the edges of each field.
  task automatic test_corner_instrs();
    send_instr(mk(OP_SET, 0, 0, 0, ADD_ACC, SRC_IMM, 32'h7FFF_FFFF, SHOW_ACC));
    send_instr(mk(OP_SET, 255, 0, 0, ADD_ACC, SRC_IMM, 32'h8000_0000, SHOW_ACC));
    send_instr(mk(OP_SET, 1, 0, 0, ADD_ACC, SRC_MEM, 0, SHOW_ACC));
    // Memory source out of range: zero and an address error.
    send_instr(mk(OP_SET, 2, 511, 0, ADD_ACC, SRC_MEM, 0, SHOW_ACC));
    send_instr(mk(OP_SET, 3, 0, 0, ADD_ACC, SRC_ZERO, 32'hFFFF_FFFF, SHOW_ACC));
    // Spare source code behaves as zero; the write itself is dropped.
    send_instr(mk(OP_SET, 511, 0, 0, ADD_ACC, SRC_SPARE, 32'hFFFF_FFFF, SHOW_ACC));
    send_instr(mk(OP_LDR, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    // Zero operand count falls back to one-operand add; sum wraps.
    send_instr(mk(OP_ADD, 0, 0, 0, ADD_DEFAULT, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_ADD, 300, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_ADD, 0, 255, 0, ADD_TWO, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_ADD, 0, 255, 4, ADD_MEM, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_ADD, 0, 1, 400, ADD_MEM, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_INC, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_DEC, 3, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_INC, 256, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_STR, 5, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_STR, 511, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_LDR, 300, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_MDR));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_MDR));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_MAR));
    send_instr(mk(OP_PAUSE, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_BAD, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_TOP, 511, 511, 511, ADD_MEM, SRC_SPARE, 32'hFFFF_FFFF, SHOW_SPARE));
    drain();
  endtask

  // Random mix with the sender working in bursts.
  task automatic test_random_mix(int n);
    gaps_on = 1'b1;
    repeat (n) send_instr(rand_instr());
    drain();
  endtask

  // Random mix with valid held high throughout.
  task automatic test_streaming(int n);
    gaps_on = 1'b0;
    repeat (n) send_instr(rand_instr());
    drain();
    gaps_on = 1'b1;
  endtask

  // END freezes the machine; later items must only report the held state.
  task automatic test_halt();
    gaps_on = 1'b1;
    send_instr(mk(OP_END, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_SHW, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_STATE));
    send_instr(mk(OP_SET, 0, 0, 0, ADD_ACC, SRC_IMM, 32'h1234_5678, SHOW_ACC));
    send_instr(mk(OP_INC, 300, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    send_instr(mk(OP_END, 0, 0, 0, ADD_ACC, SRC_IMM, 0, SHOW_ACC));
    repeat (6) send_instr(rand_instr());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_fault(string what);
    fault_cnt++;
    if (fault_cnt <= REPORT_MAX) $display("MISMATCH: %s", what);
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] got,
                             logic [WORD_W-1:0] want);
    if (got !== want)
      note_fault($sformatf("result %0d %s expected %h got %h",
                           result_idx, name, want, got));
  endtask

  // Compare each accepted result with the oldest pending outcome.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst === 1'b0 && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        note_fault($sformatf("result %0d arrived with no instruction pending",
                             result_idx));
      end else begin
        want = outcome_q.pop_front();
        check_field("shown",       WORD_W'(res.shown),      WORD_W'(want.shown));
        check_field("shown_value", res.shown_value,         want.shown_value);
        check_field("halted",      WORD_W'(res.halted),     WORD_W'(want.halted));
        check_field("paused",      WORD_W'(res.paused),     WORD_W'(want.paused));
        check_field("acc_value",   res.acc_value,           want.acc_value);
        check_field("next_pc",     WORD_W'(res.next_pc),    WORD_W'(want.next_pc));
        check_field("addr_error",  WORD_W'(res.addr_error), WORD_W'(want.addr_error));
        check_field("unknown_op",  WORD_W'(res.unknown_op), WORD_W'(want.unknown_op));
      end
      result_idx++;
    end
  end

  // Receiver stalls: rotate through always-ready, mostly-ready, a fixed
  // duty cycle and coin-flip phases so stalls land on every pipeline phase.
  initial begin : res_stall
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case ((cycle_cnt / 400) % 4)
        0:       res.ready <= 1'b1;
        1:       res.ready <= ($urandom_range(0, 3) != 0);
        2:       res.ready <= ((cycle_cnt % 7) < 4);
        default: res.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("accumulator_machine_execute test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    // Start from the reset state of the machine.
    m_acc  = '0;
    m_pc   = '0;
    m_icr  = '0;
    m_mar  = '0;
    m_mdr  = '0;
    m_halt = 1'b0;
    for (i = 0; i < MEM_DEPTH_DEF; i++) m_mem[i] = '0;

    // Hold every block input at a known value through reset.
    rst               <= 1'b1;
    req.valid         <= 1'b0;
    req.req_type      <= OP_SET;
    req.addr_a        <= '0;
    req.addr_b        <= '0;
    req.addr_c        <= '0;
    req.operand_count <= ADD_ACC;
    req.source_kind   <= SRC_IMM;
    req.immediate     <= '0;
    req.show_target   <= SHOW_ACC;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_power_on_view();
    test_corner_instrs();
    test_random_mix(700);
    test_streaming(500);
    test_random_mix(510);
    test_halt();

    // Let any stray result show up before judging.
    req.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outcome_q.size() != 0) note_fault("outcomes left without a result");

    if (fault_cnt == 0) begin
      $display("accumulator_machine_execute test passed");
    end else begin
      $display("accumulator_machine_execute test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/amx_pkg.sv
hw/rtl/amx_req_if.sv
hw/rtl/amx_res_if.sv
hw/rtl/amx_ram.sv
hw/rtl/amx_front.sv
hw/rtl/amx_back.sv
hw/rtl/accumulator_machine_execute.sv
tb/sv/tb_top.sv
